[rtl/sgsg_pkg.sv]
// Package: payload types, glyph tables and constants for the stroke glyph generator
`timescale 1ns / 1ps
package sgsg_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       restart;
  } sgsg_in_t;

  typedef struct packed {
    logic signed [15:0] seg_x0;
    logic signed [15:0] seg_y0;
    logic signed [15:0] seg_x1;
    logic signed [15:0] seg_y1;
    logic [7:0]         stroke_width;
    logic [31:0]        stroke_rgba;
    logic               last_segment;
  } sgsg_out_t;

  // Register indexes
  localparam logic [2:0] REG_GLYPH_SIZE = 3'd0;
  localparam logic [2:0] REG_BASELINE_Y = 3'd1;
  localparam logic [2:0] REG_START_X    = 3'd2;
  localparam logic [2:0] REG_THICKNESS  = 3'd3;
  localparam logic [2:0] REG_COLOR      = 3'd4;

  localparam int CFG_DW = 32;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [4:0] SPACE_ADV  = 5'd10;

  // Offset selectors: which derived glyph quantity a coordinate adds.
  localparam logic [4:0] O_ZERO   = 5'd0;
  localparam logic [4:0] O_G      = 5'd1;
  localparam logic [4:0] O_H      = 5'd2;
  localparam logic [4:0] O_G4     = 5'd3;
  localparam logic [4:0] O_G4X3   = 5'd4;
  localparam logic [4:0] O_W      = 5'd5;
  localparam logic [4:0] O_G8     = 5'd6;
  localparam logic [4:0] O_G5     = 5'd7;
  localparam logic [4:0] O_NG     = 5'd8;   // -g
  localparam logic [4:0] O_NH     = 5'd9;   // -h
  localparam logic [4:0] O_NG8    = 5'd10;  // -g/8
  localparam logic [4:0] O_NG5    = 5'd11;  // -g/5
  localparam logic [4:0] O_NGG8   = 5'd12;  // -g+g/8
  localparam logic [4:0] O_NGG5   = 5'd13;  // -g+g/5
  localparam logic [4:0] O_NGG4   = 5'd14;  // -g+g/4
  localparam logic [4:0] O_Q      = 5'd15;  // q
  localparam logic [4:0] O_W2     = 5'd16;  // w/2
  localparam logic [4:0] O_NW2    = 5'd17;  // -w/2
  localparam logic [4:0] O_W4     = 5'd18;  // w/4
  localparam logic [4:0] O_W34    = 5'd19;  // w + w/4
  localparam logic [4:0] O_WMW2   = 5'd20;  // w - w/2
  localparam logic [4:0] O_Q2     = 5'd21;
  localparam logic [4:0] O_Q3     = 5'd22;
  localparam logic [4:0] O_G2     = 5'd23;  // g/2 (T)
  localparam logic [4:0] O_Y3     = 5'd24;  // crossbar y (absolute)

  // Width kinds
  localparam logic [2:0] W_G   = 3'd0;  // g
  localparam logic [2:0] W_G3  = 3'd1;  // g - g/3
  localparam logic [2:0] W_G2  = 3'd2;  // g - g/2
  localparam logic [2:0] W_G4  = 3'd3;  // g - g/4
  localparam logic [2:0] W_G5  = 3'd4;  // g - g/5
  localparam logic [2:0] W_R   = 3'd5;  // floor(2g/3)
  localparam logic [2:0] W_W   = 3'd6;  // g + g/3
  localparam logic [2:0] W_NONE= 3'd7;

  // y3 kinds
  localparam logic [1:0] Y3_NONE = 2'd0;
  localparam logic [1:0] Y3_A    = 2'd1;
  localparam logic [1:0] Y3_G    = 2'd2;

  typedef struct packed {
    logic [4:0] x0;
    logic [4:0] y0;
    logic [4:0] x1;
    logic [4:0] y1;
  } seg_code_t;

  typedef struct packed {
    logic [2:0] nseg;     // segments
    logic [2:0] wkind;
    logic [1:0] y3kind;
    logic       adv_w;    // advance by width
    logic       adv_sp;   // advance by space
  } glyph_info_t;

  function automatic seg_code_t sc(input logic [4:0] a, input logic [4:0] b,
                                   input logic [4:0] c, input logic [4:0] d);
    seg_code_t s;
    s.x0 = a; s.y0 = b; s.x1 = c; s.y1 = d;
    return s;
  endfunction

  function automatic glyph_info_t glyph_info(input logic [7:0] ch);
    glyph_info_t gi;
    gi = '{nseg: 3'd0, wkind: W_NONE, y3kind: Y3_NONE, adv_w: 1'b0, adv_sp: 1'b0};
    case (ch)
      SPACE_CODE: gi.adv_sp = 1'b1;
      "A": gi = '{3'd3, W_G,  Y3_A,    1'b1, 1'b0};
      "B": gi = '{3'd7, W_G2, Y3_NONE, 1'b1, 1'b0};
      "C": gi = '{3'd3, W_G3, Y3_NONE, 1'b1, 1'b0};
      "D": gi = '{3'd5, W_G4, Y3_NONE, 1'b1, 1'b0};
      "E": gi = '{3'd4, W_G3, Y3_NONE, 1'b1, 1'b0};
      "F": gi = '{3'd3, W_G3, Y3_NONE, 1'b1, 1'b0};
      "G": gi = '{3'd6, W_G3, Y3_G,    1'b1, 1'b0};
      "H": gi = '{3'd3, W_G3, Y3_NONE, 1'b1, 1'b0};
      "I": gi = '{3'd1, W_G,  Y3_NONE, 1'b0, 1'b0};
      "L": gi = '{3'd2, W_G3, Y3_NONE, 1'b1, 1'b0};
      "M": gi = '{3'd4, W_G5, Y3_NONE, 1'b1, 1'b0};
      "N": gi = '{3'd3, W_G5, Y3_NONE, 1'b1, 1'b0};
      "O": gi = '{3'd4, W_G,  Y3_NONE, 1'b1, 1'b0};
      "P": gi = '{3'd4, W_G3, Y3_NONE, 1'b1, 1'b0};
      "Q": gi = '{3'd5, W_G3, Y3_NONE, 1'b1, 1'b0};
      "R": gi = '{3'd5, W_R,  Y3_NONE, 1'b1, 1'b0};
      "S": gi = '{3'd5, W_G3, Y3_NONE, 1'b1, 1'b0};
      "T": gi = '{3'd2, W_G,  Y3_NONE, 1'b1, 1'b0};
      "U": gi = '{3'd3, W_G3, Y3_NONE, 1'b1, 1'b0};
      "V": gi = '{3'd2, W_G3, Y3_NONE, 1'b1, 1'b0};
      "W": gi = '{3'd4, W_W,  Y3_NONE, 1'b1, 1'b0};
      "X": gi = '{3'd2, W_G3, Y3_NONE, 1'b1, 1'b0};
      "Y": gi = '{3'd3, W_G3, Y3_NONE, 1'b1, 1'b0};
      "Z": gi = '{3'd3, W_G3, Y3_NONE, 1'b1, 1'b0};
      default: ;
    endcase
    return gi;
  endfunction

  // Segment k of glyph ch, as offset selectors. D uses O_Q as (w/4)*3.
  function automatic seg_code_t glyph_seg(input logic [7:0] ch, input logic [2:0] k);
    seg_code_t s;
    s = sc(O_ZERO, O_ZERO, O_ZERO, O_ZERO);
    case (ch)
      "A": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_H, O_NG);
        3'd1: s = sc(O_H, O_NG, O_G, O_ZERO);
        default: s = sc(O_G4, O_Y3, O_G4X3, O_Y3);
      endcase
      "B": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_ZERO, O_NG);
        3'd1: s = sc(O_ZERO, O_ZERO, O_W, O_NG8);
        3'd2: s = sc(O_W, O_NG8, O_W, O_NG5);
        3'd3: s = sc(O_W, O_NG5, O_ZERO, O_NH);
        3'd4: s = sc(O_ZERO, O_NG, O_W, O_NGG8);
        3'd5: s = sc(O_W, O_NGG8, O_W, O_NGG5);
        default: s = sc(O_W, O_NGG5, O_ZERO, O_NH);
      endcase
      "C", "E", "F", "L": case ({ch == "E" ? 2'd1 : ch == "F" ? 2'd2 : 2'd0, k})
        {2'd0, 3'd0}, {2'd1, 3'd0}, {2'd2, 3'd0}: s = sc(O_ZERO, O_ZERO, O_ZERO, O_NG);
        {2'd0, 3'd1}, {2'd1, 3'd1}: s = sc(O_ZERO, O_ZERO, O_W, O_ZERO);
        {2'd0, 3'd2}, {2'd1, 3'd3}, {2'd2, 3'd1}: s = sc(O_ZERO, O_NG, O_W, O_NG);
        default: s = sc(O_ZERO, O_NH, O_H, O_NH);
      endcase
      "D": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_ZERO, O_NG);
        3'd1: s = sc(O_ZERO, O_ZERO, O_Q, O_NG8);
        3'd2: s = sc(O_ZERO, O_NG, O_Q, O_NGG8);
        3'd3: s = sc(O_Q, O_NGG8, O_W, O_NH);
        default: s = sc(O_Q, O_NG8, O_W, O_NH);
      endcase
      "G": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_ZERO, O_NG);
        3'd1: s = sc(O_ZERO, O_ZERO, O_W, O_ZERO);
        3'd2: s = sc(O_ZERO, O_NG, O_W, O_NG);
        3'd3: s = sc(O_W, O_NG, O_W, O_NGG4);
        3'd4: s = sc(O_W, O_ZERO, O_W, O_Y3);
        default: s = sc(O_W, O_Y3, O_W2, O_Y3);
      endcase
      "H", "U": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_ZERO, O_NG);
        3'd1: s = sc(O_W, O_ZERO, O_W, O_NG);
        default: s = (ch == "H") ? sc(O_ZERO, O_NH, O_W, O_NH)
                                 : sc(O_ZERO, O_ZERO, O_W, O_ZERO);
      endcase
      "I": s = sc(O_ZERO, O_ZERO, O_ZERO, O_NG);
      "M": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_ZERO, O_NG);
        3'd1: s = sc(O_ZERO, O_NG, O_W2, O_NH);
        3'd2: s = sc(O_W, O_NG, O_W2, O_NH);
        default: s = sc(O_W, O_ZERO, O_W, O_NG);
      endcase
      "N": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_ZERO, O_NG);
        3'd1: s = sc(O_ZERO, O_NG, O_W, O_ZERO);
        default: s = sc(O_W, O_NG, O_W, O_ZERO);
      endcase
      "O": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_G, O_ZERO);
        3'd1: s = sc(O_G, O_ZERO, O_G, O_NG);
        3'd2: s = sc(O_G, O_NG, O_ZERO, O_NG);
        default: s = sc(O_ZERO, O_NG, O_ZERO, O_ZERO);
      endcase
      "P": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_ZERO, O_NG);
        3'd1: s = sc(O_ZERO, O_NH, O_W, O_NH);
        3'd2: s = sc(O_ZERO, O_NG, O_W, O_NG);
        default: s = sc(O_W, O_NG, O_W, O_NH);
      endcase
      "Q": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_W, O_ZERO);
        3'd1: s = sc(O_ZERO, O_ZERO, O_ZERO, O_NG);
        3'd2: s = sc(O_ZERO, O_NG, O_W, O_NG);
        3'd3: s = sc(O_W, O_ZERO, O_W, O_NG);
        default: s = sc(O_WMW2, O_NW2, O_W34, O_W4);
      endcase
      "R": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_ZERO, O_NG);
        3'd1: s = sc(O_ZERO, O_NG, O_W, O_NG);
        3'd2: s = sc(O_W, O_NG, O_W, O_NH);
        3'd3: s = sc(O_W, O_NH, O_ZERO, O_NH);
        default: s = sc(O_ZERO, O_NH, O_W, O_ZERO);
      endcase
      "S": case (k)
        3'd0: s = sc(O_ZERO, O_ZERO, O_W, O_ZERO);
        3'd1: s = sc(O_W, O_ZERO, O_W, O_NH);
        3'd2: s = sc(O_W, O_NH, O_ZERO, O_NH);
        3'd3: s = sc(O_ZERO, O_NH, O_ZERO, O_NG);
        default: s = sc(O_ZERO, O_NG, O_W, O_NG);
      endcase
      "T": s = (k == 3'd0) ? sc(O_ZERO, O_NG, O_G, O_NG) : sc(O_G2, O_ZERO, O_G2, O_NG);
      "V": s = (k == 3'd0) ? sc(O_W2, O_ZERO, O_ZERO, O_NG) : sc(O_W2, O_ZERO, O_W, O_NG);
      "W": case (k)
        3'd0: s = sc(O_ZERO, O_NG, O_Q, O_ZERO);
        3'd1: s = sc(O_Q, O_ZERO, O_Q2, O_NG);
        3'd2: s = sc(O_Q2, O_NG, O_Q3, O_ZERO);
        default: s = sc(O_Q3, O_ZERO, O_W, O_NG);
      endcase
      "X": s = (k == 3'd0) ? sc(O_ZERO, O_ZERO, O_W, O_NG) : sc(O_ZERO, O_NG, O_W, O_ZERO);
      "Y": case (k)
        3'd0: s = sc(O_W2, O_ZERO, O_W2, O_NH);
        3'd1: s = sc(O_W2, O_NH, O_ZERO, O_NG);
        default: s = sc(O_W2, O_NH, O_W, O_NG);
      endcase
      "Z": case (k)
        3'd0: s = sc(O_ZERO, O_NG, O_W, O_NG);
        3'd1: s = sc(O_ZERO, O_ZERO, O_W, O_NG);
        default: s = sc(O_ZERO, O_ZERO, O_W, O_ZERO);
      endcase
      default: ;
    endcase
    return s;
  endfunction

endpackage

[rtl/stroke_glyph_segment_generator.sv]
// Top level: stroke-font glyph segment generator with a shared coordinate adder
`timescale 1ns / 1ps
// From input transfer to the first segment: latch, two derive steps, pen
//   update; then one segment per cycle while out_stall is low.
// Input: a new character is taken only once the last of its predecessor's N
//   segments (N = segment count, 0..7) has passed the single coordinate unit.
// Reset (rst_n low, synchronous): registers to their defaults, pen x to 0, idle.
module stroke_glyph_segment_generator
  import sgsg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  sgsg_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sgsg_out_t         out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV1 = 3'd1;  // g quotients
  localparam logic [2:0] ST_DIV2 = 3'd2;  // width-derived values, crossbar y
  localparam logic [2:0] ST_PEN  = 3'd3;  // pen advance
  localparam logic [2:0] ST_SEG  = 3'd4;  // emit segments

  // Configuration registers
  logic [9:0]         gsize_r;
  logic signed [15:0] base_r, startx_r;
  logic [7:0]         thick_r;
  logic [31:0]        color_r;

  logic [2:0]         state_r;
  logic [7:0]         ch_r;
  logic signed [15:0] pen_r, pen0_r;
  logic [2:0]         k_r;
  glyph_info_t        gi_r;

  // Derived glyph quantities (all nonnegative g-based values fit 11 bits)
  logic [10:0] h_r, g4_r, g5_r, g8_r, w_r, w2_r, w4_r, q_r;
  logic signed [17:0] y3_r;

  logic [10:0] g11;
  assign g11 = {1'b0, gsize_r};

  // Constant divisions of a 10-bit value by reciprocal multiply
  logic [10:0] div3_g, div5_g, div3_2g;
  logic [21:0] m3a, m5a;
  logic [22:0] m3b;
  assign m3a = 22'(gsize_r) * 22'd683;          // exact for g < 1024 after >>11
  assign m5a = 22'(gsize_r) * 22'd1639;         // >>13
  assign m3b = 23'({gsize_r, 1'b0}) * 23'd1366; // 2g/3, >>12
  assign div3_g  = 11'(m3a >> 11);
  assign div5_g  = 11'(m5a >> 13);
  assign div3_2g = 11'(m3b >> 12);

  // Crossbar y: trunc((3B - 2h)/3) = B - ceil-toward-zero handling of 2h/3
  // and trunc((5B - 2g)/5) likewise; computed as B + trunc(-(2v)/d) when
  // B*d - 2v keeps B's fractional-free part: value = B - floor or ceil.
  logic signed [19:0] num_y3;
  logic [11:0]        two_v;
  logic [10:0]        fq;          // floor(two_v / d)
  logic               fexact;
  logic [23:0]        fm3, fm5;
  logic [11:0]        fprod;

  always_comb begin
    two_v = (gi_r.y3kind == Y3_A) ? {h_r, 1'b0} : {1'b0, g11};
    if (gi_r.y3kind == Y3_G) two_v = {g11, 1'b0};
    fm3 = 24'(two_v) * 24'd2731;  // /3, >>13
    fm5 = 24'(two_v) * 24'd3277;  // /5, >>14
    fq  = (gi_r.y3kind == Y3_A) ? 11'(fm3 >> 13) : 11'(fm5 >> 14);
    fprod = (gi_r.y3kind == Y3_A) ? 12'(fq) * 12'd3 : 12'(fq) * 12'd5;
    fexact = (fprod == two_v);
    // (dB - 2v)/d truncated: if numerator >= 0 it is B - ceil(2v/d) .. floor
    num_y3 = 20'(base_r) * ((gi_r.y3kind == Y3_A) ? 20'sd3 : 20'sd5) - 20'(two_v);
  end

  // Shared coordinate unit: base + offset or the absolute crossbar y, saturated
  seg_code_t          code;
  logic signed [17:0] offs [4];
  logic signed [17:0] sum  [4];
  logic signed [15:0] sat  [4];
  logic [4:0]         sel  [4];
  logic signed [15:0] basev[4];

  function automatic logic signed [17:0] off_val(
      input logic [4:0] s, input logic [10:0] g, h, g4, g5, g8, w, w2, w4, q);
    logic signed [17:0] v;
    case (s)
      O_ZERO: v = '0;
      O_G:    v = 18'(g);
      O_H:    v = 18'(h);
      O_G4:   v = 18'(g4);
      O_G4X3: v = 18'(g4) * 18'sd3;
      O_W:    v = 18'(w);
      O_G8:   v = 18'(g8);
      O_G5:   v = 18'(g5);
      O_NG:   v = -18'(g);
      O_NH:   v = -18'(h);
      O_NG8:  v = -18'(g8);
      O_NG5:  v = -18'(g5);
      O_NGG8: v = 18'(g8) - 18'(g);
      O_NGG5: v = 18'(g5) - 18'(g);
      O_NGG4: v = 18'(g4) - 18'(g);
      O_Q:    v = 18'(q);
      O_W2:   v = 18'(w2);
      O_NW2:  v = -18'(w2);
      O_W4:   v = 18'(w4);
      O_W34:  v = 18'(w) + 18'(w4);
      O_WMW2: v = 18'(w) - 18'(w2);
      O_Q2:   v = 18'(q) * 18'sd2;
      O_Q3:   v = 18'(q) * 18'sd3;
      O_G2:   v = 18'(h);
      default: v = '0;
    endcase
    return v;
  endfunction

  assign code = glyph_seg(ch_r, k_r);
  assign sel[0] = code.x0;
  assign sel[1] = code.y0;
  assign sel[2] = code.x1;
  assign sel[3] = code.y1;
  assign basev[0] = pen0_r;
  assign basev[1] = base_r;
  assign basev[2] = pen0_r;
  assign basev[3] = base_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      offs[i] = off_val(sel[i], g11, h_r, g4_r, g5_r, g8_r, w_r, w2_r, w4_r, q_r);
      sum[i]  = (sel[i] == O_Y3) ? y3_r : 18'(basev[i]) + offs[i];
      if (sum[i] > 18'sd32767)       sat[i] = 16'sh7fff;
      else if (sum[i] < -18'sd32768) sat[i] = -16'sh8000;
      else                           sat[i] = sum[i][15:0];
    end
  end

  // Output register / skid: one segment held until taken
  logic      out_valid_r;
  sgsg_out_t out_r;
  logic      seg_fire;
  assign seg_fire = (state_r == ST_SEG) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic [2:0]         state_nxt;
  logic signed [17:0] pen_sum;
  logic [10:0]        adv;

  always_comb begin
    if (gi_r.adv_sp)     adv = 11'(SPACE_ADV);
    else if (gi_r.adv_w) adv = w_r;
    else                 adv = '0;
    pen_sum = 18'(pen0_r) + 18'(adv);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV1;
      ST_DIV1: state_nxt = ST_DIV2;
      ST_DIV2: state_nxt = ST_PEN;
      ST_PEN:  state_nxt = (gi_r.nseg == 3'd0) ? ST_IDLE : ST_SEG;
      ST_SEG:  if (seg_fire && k_r == gi_r.nseg - 3'd1) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsize_r     <= 10'd32;
      base_r      <= '0;
      startx_r    <= '0;
      thick_r     <= 8'd1;
      color_r     <= '1;
      pen_r       <= '0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GLYPH_SIZE: gsize_r  <= cfg_wdata[9:0];
          REG_BASELINE_Y: base_r   <= cfg_wdata[15:0];
          REG_START_X:    startx_r <= cfg_wdata[15:0];
          REG_THICKNESS:  thick_r  <= cfg_wdata[7:0];
          REG_COLOR:      color_r  <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_IDLE && in_valid) begin
        ch_r <= in_data.char_code;
        gi_r <= glyph_info(in_data.char_code);
        k_r  <= '0;
        if (in_data.restart) pen_r <= startx_r;
      end
      if (state_r == ST_PEN) begin
        // hold the drawing origin, advance the stored pen
        if (pen_sum > 18'sd32767) pen_r <= 16'sh7fff;
        else                      pen_r <= pen_sum[15:0];
      end
      if (seg_fire) begin
        out_valid_r <= 1'b1;
        k_r         <= k_r + 3'd1;
      end
    end
  end

  // Payload and derived values, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) pen0_r <= (in_data.restart) ? startx_r : pen_r;
    if (state_r == ST_DIV1) begin
      h_r  <= g11 >> 1;
      g4_r <= g11 >> 2;
      g5_r <= div5_g;
      g8_r <= g11 >> 3;
      unique case (gi_r.wkind)
        W_G:  w_r <= g11;
        W_G3: w_r <= g11 - div3_g;
        W_G2: w_r <= g11 - (g11 >> 1);
        W_G4: w_r <= g11 - (g11 >> 2);
        W_G5: w_r <= g11 - div5_g;
        W_R:  w_r <= div3_2g;
        W_W:  w_r <= g11 + div3_g;
        default: w_r <= '0;
      endcase
    end
    if (state_r == ST_DIV2) begin
      w2_r <= w_r >> 1;
      w4_r <= w_r >> 2;
      q_r  <= (gi_r.wkind == W_G4) ? 11'(w_r >> 2) * 11'd3 : (w_r >> 2);
      // truncate toward zero: floor for a nonnegative numerator, else ceil
      if (num_y3 >= 0)
        y3_r <= 18'(base_r) - 18'(fq) - ((fexact) ? 18'sd0 : 18'sd1);
      else
        y3_r <= 18'(base_r) - 18'(fq);
    end
    if (seg_fire) begin
      out_r.seg_x0       <= sat[0];
      out_r.seg_y0       <= sat[1];
      out_r.seg_x1       <= sat[2];
      out_r.seg_y1       <= sat[3];
      out_r.stroke_width <= thick_r;
      out_r.stroke_rgba  <= color_r;
      out_r.last_segment <= (k_r == gi_r.nseg - 3'd1);
    end
  end

`ifndef ASSERT_OFF
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEG) |-> (k_r < gi_r.nseg)) else $error("segment index past glyph");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r) else $error("pending segment dropped");
`endif

endmodule

[dv/sgsg_checker.sv]
// Checker: predicts glyph segments from watched transfers and compares results
`timescale 1ns / 1ps
module sgsg_checker
  import sgsg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  sgsg_in_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  sgsg_out_t         out_data,
  output int                fail_count,
  output int                pending_segs,
  output int                seg_count
);
  logic [9:0]         size_r;
  logic signed [15:0] base_r;
  logic signed [15:0] startx_r;
  logic [7:0]         thick_r;
  logic [31:0]        color_r;
  logic signed [15:0] pen_r;

  sgsg_out_t segs_q[$];
  sgsg_out_t glyph_q[$];

  assign pending_segs = segs_q.size();

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic add_seg(input longint x0, input longint y0, input longint x1,
                         input longint y1);
    sgsg_out_t s;
    s.seg_x0 = clamp16(x0);
    s.seg_y0 = clamp16(y0);
    s.seg_x1 = clamp16(x1);
    s.seg_y1 = clamp16(y1);
    s.stroke_width = thick_r;
    s.stroke_rgba = color_r;
    s.last_segment = 1'b0;
    glyph_q.push_back(s);
  endtask

  // Build the segment list for one character and advance the pen.
  task automatic draw_glyph(input sgsg_in_t item);
    longint p, b, g, h, w, q, m, y3, x2, y2, adv;
    p = 0; b = 0; g = 0; h = 0; w = 0; q = 0; m = 0; y3 = 0; x2 = 0; y2 = 0; adv = 0;
    glyph_q.delete();
    if (item.restart) pen_r = startx_r;
    p = pen_r; b = base_r; g = size_r; h = g / 2;
    case (item.char_code)
      SPACE_CODE: adv = SPACE_ADV;
      "A": begin
        y3 = (3 * b - 2 * h) / 3;
        add_seg(p, b, p + h, b - g); add_seg(p + h, b - g, p + g, b);
        add_seg(p + g / 4, y3, p + (g / 4) * 3, y3); adv = g;
      end
      "B": begin
        w = g - g / 2;
        add_seg(p, b, p, b - g); add_seg(p, b, p + w, b - g / 8);
        add_seg(p + w, b - g / 8, p + w, b - g / 5); add_seg(p + w, b - g / 5, p, b - h);
        add_seg(p, b - g, p + w, b - g + g / 8);
        add_seg(p + w, b - g + g / 8, p + w, b - g + g / 5);
        add_seg(p + w, b - g + g / 5, p, b - h); adv = w;
      end
      "C": begin
        w = g - g / 3;
        add_seg(p, b, p, b - g); add_seg(p, b, p + w, b); add_seg(p, b - g, p + w, b - g);
        adv = w;
      end
      "D": begin
        w = g - g / 4; q = (w / 4) * 3;
        add_seg(p, b, p, b - g); add_seg(p, b, p + q, b - g / 8);
        add_seg(p, b - g, p + q, b - g + g / 8); add_seg(p + q, b - g + g / 8, p + w, b - h);
        add_seg(p + q, b - g / 8, p + w, b - h); adv = w;
      end
      "E": begin
        w = g - g / 3;
        add_seg(p, b, p, b - g); add_seg(p, b, p + w, b); add_seg(p, b - h, p + h, b - h);
        add_seg(p, b - g, p + w, b - g); adv = w;
      end
      "F": begin
        w = g - g / 3;
        add_seg(p, b, p, b - g); add_seg(p, b - g, p + w, b - g);
        add_seg(p, b - h, p + h, b - h); adv = w;
      end
      "G": begin
        w = g - g / 3; y3 = (5 * b - 2 * g) / 5;
        add_seg(p, b, p, b - g); add_seg(p, b, p + w, b); add_seg(p, b - g, p + w, b - g);
        add_seg(p + w, b - g, p + w, b - g + g / 4); add_seg(p + w, b, p + w, y3);
        add_seg(p + w, y3, p + w / 2, y3); adv = w;
      end
      "H": begin
        w = g - g / 3;
        add_seg(p, b, p, b - g); add_seg(p + w, b, p + w, b - g);
        add_seg(p, b - h, p + w, b - h); adv = w;
      end
      "I": add_seg(p, b, p, b - g);
      "L": begin
        w = g - g / 3; add_seg(p, b, p, b - g); add_seg(p, b, p + w, b); adv = w;
      end
      "M": begin
        w = g - g / 5;
        add_seg(p, b, p, b - g); add_seg(p, b - g, p + w / 2, b - h);
        add_seg(p + w, b - g, p + w / 2, b - h); add_seg(p + w, b, p + w, b - g); adv = w;
      end
      "N": begin
        w = g - g / 5;
        add_seg(p, b, p, b - g); add_seg(p, b - g, p + w, b); add_seg(p + w, b - g, p + w, b);
        adv = w;
      end
      "O": begin
        add_seg(p, b, p + g, b); add_seg(p + g, b, p + g, b - g);
        add_seg(p + g, b - g, p, b - g); add_seg(p, b - g, p, b); adv = g;
      end
      "P": begin
        w = g - g / 3;
        add_seg(p, b, p, b - g); add_seg(p, b - h, p + w, b - h);
        add_seg(p, b - g, p + w, b - g); add_seg(p + w, b - g, p + w, b - h); adv = w;
      end
      "Q": begin
        w = g - g / 3; x2 = p + w; y2 = b - g;
        add_seg(p, b, x2, b); add_seg(p, b, p, y2); add_seg(p, y2, x2, y2);
        add_seg(x2, b, x2, y2); add_seg(x2 - w / 2, b - w / 2, x2 + w / 4, b + w / 4);
        adv = w;
      end
      "R": begin
        m = (2 * g) / 3;
        add_seg(p, b, p, b - g); add_seg(p, b - g, p + m, b - g);
        add_seg(p + m, b - g, p + m, b - h); add_seg(p + m, b - h, p, b - h);
        add_seg(p, b - h, p + m, b); adv = m;
      end
      "S": begin
        w = g - g / 3;
        add_seg(p, b, p + w, b); add_seg(p + w, b, p + w, b - h);
        add_seg(p + w, b - h, p, b - h); add_seg(p, b - h, p, b - g);
        add_seg(p, b - g, p + w, b - g); adv = w;
      end
      "T": begin
        add_seg(p, b - g, p + g, b - g); add_seg(p + g / 2, b, p + g / 2, b - g); adv = g;
      end
      "U": begin
        w = g - g / 3;
        add_seg(p, b, p, b - g); add_seg(p + w, b, p + w, b - g); add_seg(p, b, p + w, b);
        adv = w;
      end
      "V": begin
        w = g - g / 3;
        add_seg(p + w / 2, b, p, b - g); add_seg(p + w / 2, b, p + w, b - g); adv = w;
      end
      "W": begin
        w = g + g / 3; q = w / 4; y2 = b - g;
        add_seg(p, y2, p + q, b); add_seg(p + q, b, p + q * 2, y2);
        add_seg(p + q * 2, y2, p + q * 3, b); add_seg(p + q * 3, b, p + w, y2); adv = w;
      end
      "X": begin
        w = g - g / 3;
        add_seg(p, b, p + w, b - g); add_seg(p, b - g, p + w, b); adv = w;
      end
      "Y": begin
        w = g - g / 3;
        add_seg(p + w / 2, b, p + w / 2, b - h); add_seg(p + w / 2, b - h, p, b - g);
        add_seg(p + w / 2, b - h, p + w, b - g); adv = w;
      end
      "Z": begin
        w = g - g / 3;
        add_seg(p, b - g, p + w, b - g); add_seg(p, b, p + w, b - g); add_seg(p, b, p + w, b);
        adv = w;
      end
      default: adv = 0;
    endcase
    pen_r = clamp16(p + adv);
    if (glyph_q.size() > 0) glyph_q[glyph_q.size() - 1].last_segment = 1'b1;
    foreach (glyph_q[i]) segs_q.push_back(glyph_q[i]);
  endtask

  task automatic compare_seg(input sgsg_out_t got);
    sgsg_out_t exp_s;
    if (segs_q.size() == 0) begin
      $error("segment with no expectation: x0=%0d y0=%0d", got.seg_x0, got.seg_y0);
      fail_count++;
      return;
    end
    exp_s = segs_q.pop_front();
    if (got.seg_x0 !== exp_s.seg_x0) begin
      $error("seg_x0 exp %0d got %0d", exp_s.seg_x0, got.seg_x0); fail_count++;
    end
    if (got.seg_y0 !== exp_s.seg_y0) begin
      $error("seg_y0 exp %0d got %0d", exp_s.seg_y0, got.seg_y0); fail_count++;
    end
    if (got.seg_x1 !== exp_s.seg_x1) begin
      $error("seg_x1 exp %0d got %0d", exp_s.seg_x1, got.seg_x1); fail_count++;
    end
    if (got.seg_y1 !== exp_s.seg_y1) begin
      $error("seg_y1 exp %0d got %0d", exp_s.seg_y1, got.seg_y1); fail_count++;
    end
    if (got.stroke_width !== exp_s.stroke_width) begin
      $error("stroke_width exp %0d got %0d", exp_s.stroke_width, got.stroke_width);
      fail_count++;
    end
    if (got.stroke_rgba !== exp_s.stroke_rgba) begin
      $error("stroke_rgba exp %h got %h", exp_s.stroke_rgba, got.stroke_rgba); fail_count++;
    end
    if (got.last_segment !== exp_s.last_segment) begin
      $error("last_segment exp %0b got %0b", exp_s.last_segment, got.last_segment);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 10'd32; base_r <= '0; startx_r <= '0; thick_r <= 8'd1;
      color_r <= '1; pen_r = '0; segs_q.delete();
      fail_count = 0; seg_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GLYPH_SIZE: size_r <= cfg_wdata[9:0];
          REG_BASELINE_Y: base_r <= cfg_wdata[15:0];
          REG_START_X:    startx_r <= cfg_wdata[15:0];
          REG_THICKNESS:  thick_r <= cfg_wdata[7:0];
          REG_COLOR:      color_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        compare_seg(out_data);
        seg_count <= seg_count + 1;
      end
      if (in_valid && !in_stall) draw_glyph(in_data);
    end
  end
endmodule

[dv/tb_stroke_glyph_segment_generator.sv]
// Testbench top: stimulus, configuration phases and verdict for the glyph generator
`timescale 1ns / 1ps
module tb_stroke_glyph_segment_generator
  import sgsg_pkg::*;
();

  localparam int STALL_LIMIT = 4000;   // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 16;    // settling margin after the last segment

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  sgsg_in_t          in_data;
  logic              out_valid;
  logic              out_stall;
  sgsg_out_t         out_data;
  int                fail_count;
  int                pending_segs;
  int                seg_count;
  int                chars_sent;
  int                idle_cycles;
  int                send_gap_pct;
  int                recv_gap_pct;

  stroke_glyph_segment_generator uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  sgsg_checker checker_i (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending_segs, .seg_count
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Receiver: stall at random with the current percentage.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_gap_pct);
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Hold the write enable high across back-to-back writes; set_all drops it.
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Present one character and hold it until the block takes the transfer.
  // Valid stays high after the transfer; the next call or drain() updates it.
  task automatic send_char(input logic [7:0] code, input logic rs);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.char_code <= code;
    in_data.restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  // Drop valid, wait until every predicted segment has come back, then settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_segs != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_all(input logic [9:0] gs, input logic [15:0] by, input logic [15:0] sx,
                         input logic [7:0] th, input logic [31:0] co);
    write_reg(REG_GLYPH_SIZE, CFG_DW'(gs));
    write_reg(REG_BASELINE_Y, CFG_DW'(by));
    write_reg(REG_START_X, CFG_DW'(sx));
    write_reg(REG_THICKNESS, CFG_DW'(th));
    write_reg(REG_COLOR, co);
    cfg_we <= 1'b0;
  endtask

  // Mostly capital letters A..Z, plus spaces and random byte codes; random_chars adds restarts.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 75) return 8'("A" + $urandom_range(25));
    if (r < 87) return SPACE_CODE;
    return 8'($urandom_range(255));
  endfunction

  task automatic random_chars(input int n);
    repeat (n) send_char(pick_char(), ($urandom_range(15) == 0));
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 1'b0; in_data = '0; chars_sent = 0;
    send_gap_pct = 0; recv_gap_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: A..Z except L and V at reset settings (so J, K too), space, lower case, 0xFF.
    for (int c = "A"; c <= "Z"; c++) if (c != "L" && c != "V") send_char(8'(c), 1'b0);
    send_char(SPACE_CODE, 1'b0);
    send_char("a", 1'b0);
    send_char(8'hFF, 1'b1);
    drain();

    // Extremes: largest glyph near the top edge so the pen and points saturate.
    set_all(10'd1023, 16'h7FFF, 16'h7F00, 8'd0, 32'h0);
    send_char("W", 1'b1); send_char("L", 1'b0); send_char("V", 1'b0);
    send_char("Q", 1'b0); send_char(SPACE_CODE, 1'b0);
    drain();
    set_all(10'd0, 16'h8000, 16'h8000, 8'd255, 32'hA5A5_5A5A);
    send_char("B", 1'b1); send_char("G", 1'b0); send_char("A", 1'b0);
    drain();

    // Random phases with changing settings and idling patterns.
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 28 : (ph == 1) ? 61 : 0;
      recv_gap_pct = (ph == 0) ? 61 : (ph == 1) ? 28 : 0;
      for (int sub = 0; sub < 2; sub++) begin
        set_all(10'($urandom_range(1023) >> $urandom_range(5)), 16'($urandom),
                16'($urandom), 8'($urandom_range(255)), $urandom);
        random_chars(60);
        drain();
      end
      set_all(ph == 0 ? 10'd1 : 10'(3 + $urandom_range(60)),
              $urandom_range(1) ? 16'h7FFF : 16'($urandom),
              $urandom_range(1) ? 16'h8000 : 16'($urandom),
              8'($urandom_range(1, 255)), $urandom);
      random_chars(12);
      drain();
    end

    $display("covered %0d characters and %0d segments across glyph sizes 0..1023,",
             chars_sent, seg_count);
    $display("restarts, saturated pens and three idling patterns");
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
